FILE: hdl/bbp_pkg.sv
// Shared types and constants for the bimodal branch predictor with target buffer.
// Used by the controller, the datapath and the top level; depends on nothing.
package bbp_pkg;

    // Table depth; must be a power of two, 4 to 65536.
    localparam int ENTRIES = 1024;
    localparam int IDX_W   = $clog2(ENTRIES);

    // Field widths fixed by the interface.
    localparam int PC_W  = 32;
    localparam int IMM_W = 16;
    localparam int CNT_W = 2;

    // Counter limits and the fetch step.
    localparam logic [CNT_W-1:0] CNT_MAX   = 2'b11;
    localparam logic [CNT_W-1:0] CNT_MIN   = 2'b00;
    localparam logic [PC_W-1:0]  INSTR_STEP = 32'd4;

    // Operation codes of an input transaction.
    typedef enum logic [1:0] {
        OP_PREDICT = 2'd0,
        OP_FILL    = 2'd1,
        OP_RESOLVE = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_we;   // write zeros at the sweep index
        logic capture;  // register the input transaction and read the tables
        logic commit;   // update tables and flags, load the result register
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last; // sweep is at the last entry
        logic out_free; // result register can take a new result this cycle
    } t_dp_status;

endpackage

FILE: hdl/bbp_ctrl.sv
// Controller state machine of the branch predictor: clearing sweep, accept, execute.
// Depends on bbp_pkg for the state type and the command/status structs.
module bbp_ctrl import bbp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       o_stall
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Outputs to the datapath and the input channel.
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
            end
            ST_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: hdl/bbp_datapath.sv
// Datapath of the branch predictor: tag, target and counter memories, fetch flags,
// next-address arithmetic and the result register. Depends on bbp_pkg.
module bbp_datapath import bbp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl_cmd          i_cmd,
    output t_dp_status         o_status,
    input  logic [1:0]         i_op,
    input  logic [PC_W-1:0]    i_pc,
    input  logic signed [IMM_W-1:0] i_imm_offset,
    input  logic               i_is_bne,
    input  logic               i_compare_zero,
    input  logic               i_was_predicted,
    input  logic               i_stall,
    output logic               o_valid,
    output logic               o_predict_taken,
    output logic               o_redirect,
    output logic               o_flush,
    output logic [PC_W-1:0]    o_next_pc
);

    // Table memories.
    logic [PC_W-1:0]  mem_tag [ENTRIES];
    logic [PC_W-1:0]  mem_tgt [ENTRIES];
    logic [CNT_W-1:0] mem_cnt [ENTRIES];

    // Captured transaction and registered table reads.
    t_op               r_op;
    logic [PC_W-1:0]   r_pc;
    logic [IMM_W-1:0]  r_imm;
    logic              r_is_bne;
    logic              r_cz;
    logic              r_pred;
    logic [IDX_W-1:0]  r_idx;
    logic [PC_W-1:0]   r_tag_rd;
    logic [PC_W-1:0]   r_tgt_rd;
    logic [CNT_W-1:0]  r_cnt_rd;

    // Clearing sweep index and fetch flags.
    logic [IDX_W-1:0]  r_clr_idx;
    logic              r_fetched_taken;
    logic              r_fetched_seq;

    // Result register.
    logic              r_out_valid;
    logic              r_out_taken;
    logic              r_out_redirect;
    logic              r_out_flush;
    logic [PC_W-1:0]   r_out_next_pc;

    // Execute-stage combinational values.
    logic [IDX_W-1:0]  in_idx;
    logic [PC_W-1:0]   pc_seq;
    logic [PC_W-1:0]   pc_branch;
    logic              hit_taken;
    logic              br_taken;
    logic [CNT_W-1:0]  cnt_next;
    logic              n_taken;
    logic              n_redirect;
    logic              n_flush;
    logic [PC_W-1:0]   n_next_pc;
    logic              n_fetched_taken;
    logic              n_fetched_seq;
    logic              tag_we;
    logic              cnt_we;

    // Direct-mapped slot: word address modulo the depth.
    assign in_idx = i_pc[IDX_W+1:2];

    // Capture the transaction and read all three tables at its slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= t_op'(i_op);
            r_pc     <= i_pc;
            r_imm    <= i_imm_offset;
            r_is_bne <= i_is_bne;
            r_cz     <= i_compare_zero;
            r_pred   <= i_was_predicted;
            r_idx    <= in_idx;
            r_tag_rd <= mem_tag[in_idx];
            r_tgt_rd <= mem_tgt[in_idx];
            r_cnt_rd <= mem_cnt[in_idx];
        end
    end

    // Address arithmetic, wrapping modulo 2^32.
    assign pc_seq    = r_pc + INSTR_STEP;
    assign pc_branch = pc_seq + {{(PC_W-IMM_W-2){r_imm[IMM_W-1]}}, r_imm, 2'b00};

    assign hit_taken = (r_tag_rd == r_pc) && r_cnt_rd[CNT_W-1];
    assign br_taken  = r_is_bne ? !r_cz : r_cz;

    // Saturating counter update.
    always_comb begin
        cnt_next = r_cnt_rd;
        if (br_taken) begin
            if (r_cnt_rd != CNT_MAX) begin
                cnt_next = r_cnt_rd + 2'd1;
            end
        end else begin
            if (r_cnt_rd != CNT_MIN) begin
                cnt_next = r_cnt_rd - 2'd1;
            end
        end
    end

    // Result and flag update for the captured transaction.
    always_comb begin
        n_taken         = 1'b0;
        n_redirect      = 1'b0;
        n_flush         = 1'b0;
        n_next_pc       = '0;
        n_fetched_taken = r_fetched_taken;
        n_fetched_seq   = r_fetched_seq;
        tag_we          = 1'b0;
        cnt_we          = 1'b0;
        case (r_op)
            OP_PREDICT: begin
                if (hit_taken) begin
                    n_taken         = 1'b1;
                    n_redirect      = 1'b1;
                    n_next_pc       = r_tgt_rd;
                    n_fetched_taken = 1'b1;
                end else begin
                    n_next_pc     = pc_seq;
                    n_fetched_seq = 1'b1;
                end
            end
            OP_FILL: begin
                tag_we = 1'b1;
            end
            OP_RESOLVE: begin
                cnt_we = 1'b1;
                if (br_taken) begin
                    if (!r_pred) begin
                        n_flush   = 1'b1;
                        n_next_pc = pc_branch;
                    end else if (!r_fetched_taken) begin
                        n_redirect = 1'b1;
                        n_next_pc  = pc_branch;
                    end
                    n_fetched_taken = 1'b0;
                end else begin
                    if (r_pred) begin
                        n_flush   = 1'b1;
                        n_next_pc = pc_seq;
                    end else if (!r_fetched_seq) begin
                        n_redirect = 1'b1;
                        n_next_pc  = pc_seq;
                    end
                    n_fetched_seq = 1'b0;
                end
            end
            default: begin
                n_taken = 1'b0;
            end
        endcase
    end

    // Memory writes: the clearing sweep after reset, then fills and counter updates.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we) begin
            mem_tag[r_clr_idx] <= '0;
            mem_tgt[r_clr_idx] <= '0;
        end else if (i_cmd.commit && tag_we) begin
            mem_tag[r_idx] <= r_pc;
            mem_tgt[r_idx] <= pc_branch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we) begin
            mem_cnt[r_clr_idx] <= CNT_MIN;
        end else if (i_cmd.commit && cnt_we) begin
            mem_cnt[r_idx] <= cnt_next;
        end
    end

    // Sweep index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_we) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // Fetch flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fetched_taken <= 1'b0;
            r_fetched_seq   <= 1'b0;
        end else if (i_cmd.commit) begin
            r_fetched_taken <= n_fetched_taken;
            r_fetched_seq   <= n_fetched_seq;
        end
    end

    // Result register valid: set on commit, cleared when the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_taken    <= n_taken;
            r_out_redirect <= n_redirect;
            r_out_flush    <= n_flush;
            r_out_next_pc  <= n_next_pc;
        end
    end

    assign o_status.clr_last = (r_clr_idx == {IDX_W{1'b1}});
    assign o_status.out_free = !r_out_valid || !i_stall;

    assign o_valid         = r_out_valid;
    assign o_predict_taken = r_out_taken;
    assign o_redirect      = r_out_redirect;
    assign o_flush         = r_out_flush;
    assign o_next_pc       = r_out_next_pc;

endmodule

FILE: hdl/btb_bimodal_branch_predictor_unit.sv
// Bimodal two-bit branch predictor with a direct-mapped branch target buffer.
// Top level: joins the controller and the datapath; depends on bbp_pkg.
//
// Input channel (i_valid / o_stall) carries one transaction: predict at fetch,
// fill the target buffer, resolve a beq/bne branch, or no operation. Output
// channel (o_valid / i_stall) returns exactly one result per input transaction.
// All three tables are indexed by the word address modulo the table depth.
//
// After reset a clearing sweep writes zeros to every table entry, one entry a
// cycle, over all 1024 entries (the table depth); o_stall stays high meanwhile.
// A transaction accepted at an edge reads the tables into registers; in the
// execute step, once the result register is free, the tables and fetch flags
// are updated and the result register loads and offers the result. The input
// is taken again only after the return to idle, so a new transaction is not
// accepted before the last one has passed the registered memory read and the
// update step. If the receiver stalls on a full result register, the next
// transaction waits in execute and o_stall stays high; the result holds.
module btb_bimodal_branch_predictor_unit import bbp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_op,
    input  logic [PC_W-1:0]         i_pc,
    input  logic signed [IMM_W-1:0] i_imm_offset,
    input  logic                    i_is_bne,
    input  logic                    i_compare_zero,
    input  logic                    i_was_predicted,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_predict_taken,
    output logic                    o_redirect,
    output logic                    o_flush,
    output logic [PC_W-1:0]         o_next_pc
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Sequencing of the sweep, accept and execute steps.
    bbp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    // Tables, flags, arithmetic and result register.
    bbp_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_op            (i_op),
        .i_pc            (i_pc),
        .i_imm_offset    (i_imm_offset),
        .i_is_bne        (i_is_bne),
        .i_compare_zero  (i_compare_zero),
        .i_was_predicted (i_was_predicted),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_predict_taken (o_predict_taken),
        .o_redirect      (o_redirect),
        .o_flush         (o_flush),
        .o_next_pc       (o_next_pc)
    );

endmodule
